@@ design/power_cell_locate_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Power cell locate unit: assertion macros
// Shared concurrent-assertion wrappers, clocked on clk with async reset.
// ---------------------------------------------------------------------------
`ifndef POWER_CELL_LOCATE_UNIT_DEFINES_SVH
`define POWER_CELL_LOCATE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PLC_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("plc: same-cycle check failed");

// Next-cycle implication.
`define PLC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("plc: next-cycle check failed");

`endif

@@ design/plc_pkg.sv @@
// ---------------------------------------------------------------------------
// plc_pkg
// Widths, codes and bus structs for the power cell locate unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package plc_pkg;

	localparam int MAX_SITES  = 64;
	localparam int MAX_PLANES = 16;
	localparam int COORD_W    = 16;
	localparam int SCALAR_W   = 41;
	localparam int POWER_W    = 42;
	localparam int SUM_W      = 44;   // 3 * 2^32 + 2^40 fits with margin
	localparam int PROD_W     = 2 * (COORD_W + 1) + 1;
	localparam int SITE_AW    = $clog2(MAX_SITES);
	localparam int PLANE_AW   = $clog2(MAX_PLANES);
	localparam int SLOT_W     = 6;
	localparam int TAG_W      = 16;
	localparam int CNT_W      = SITE_AW + 1;

	localparam logic [1:0] MODE_WR_SITE  = 2'd0;
	localparam logic [1:0] MODE_WR_PLANE = 2'd1;
	localparam logic [1:0] MODE_LOCATE   = 2'd2;
	localparam logic [1:0] MODE_LIST     = 2'd3;

	localparam logic [1:0] CFG_SITE_COUNT  = 2'd0;
	localparam logic [1:0] CFG_PLANE_COUNT = 2'd1;

	typedef struct packed {
		logic                       site_we;
		logic                       plane_we;
		logic [SLOT_W-1:0]          slot;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic signed [SCALAR_W-1:0] scalar;
		logic [TAG_W-1:0]           tag;
	} tbl_wr_t;

	typedef struct packed {
		logic                rd_en;
		logic [SITE_AW-1:0]  site_addr;
		logic [PLANE_AW-1:0] plane_addr;
	} tbl_rd_t;

endpackage

@@ design/plc_tables.sv @@
// ---------------------------------------------------------------------------
// plc_tables
// Site and boundary plane tables, one write and one registered read each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plc_tables (
	input  logic                                 clk,
	input  plc_pkg::tbl_wr_t                     wr,
	input  plc_pkg::tbl_rd_t                     rd,
	output logic signed [plc_pkg::COORD_W-1:0]   site_x,
	output logic signed [plc_pkg::COORD_W-1:0]   site_y,
	output logic signed [plc_pkg::COORD_W-1:0]   site_z,
	output logic signed [plc_pkg::SCALAR_W-1:0]  site_w,
	output logic [plc_pkg::TAG_W-1:0]            site_tag,
	output logic [3*plc_pkg::COORD_W-1:0]        plane_dir,
	output logic signed [plc_pkg::SCALAR_W-1:0]  plane_off
);

	logic signed [plc_pkg::COORD_W-1:0]  sx_mem [plc_pkg::MAX_SITES];
	logic signed [plc_pkg::COORD_W-1:0]  sy_mem [plc_pkg::MAX_SITES];
	logic signed [plc_pkg::COORD_W-1:0]  sz_mem [plc_pkg::MAX_SITES];
	logic signed [plc_pkg::SCALAR_W-1:0] sw_mem [plc_pkg::MAX_SITES];
	logic [plc_pkg::TAG_W-1:0]           st_mem [plc_pkg::MAX_SITES];
	logic [3*plc_pkg::COORD_W-1:0]       pd_mem [plc_pkg::MAX_PLANES];
	logic signed [plc_pkg::SCALAR_W-1:0] po_mem [plc_pkg::MAX_PLANES];

	logic plane_in_range;
	assign plane_in_range = (wr.slot[plc_pkg::SLOT_W-1:plc_pkg::PLANE_AW] == '0);

	always_ff @(posedge clk) begin
		if (wr.site_we) begin
			sx_mem[wr.slot[plc_pkg::SITE_AW-1:0]] <= wr.x;
			sy_mem[wr.slot[plc_pkg::SITE_AW-1:0]] <= wr.y;
			sz_mem[wr.slot[plc_pkg::SITE_AW-1:0]] <= wr.z;
			sw_mem[wr.slot[plc_pkg::SITE_AW-1:0]] <= wr.scalar;
			st_mem[wr.slot[plc_pkg::SITE_AW-1:0]] <= wr.tag;
		end
		if (rd.rd_en) begin
			site_x   <= sx_mem[rd.site_addr];
			site_y   <= sy_mem[rd.site_addr];
			site_z   <= sz_mem[rd.site_addr];
			site_w   <= sw_mem[rd.site_addr];
			site_tag <= st_mem[rd.site_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.plane_we && plane_in_range) begin
			pd_mem[wr.slot[plc_pkg::PLANE_AW-1:0]] <= {wr.z, wr.y, wr.x};
			po_mem[wr.slot[plc_pkg::PLANE_AW-1:0]] <= wr.scalar;
		end
		if (rd.rd_en) begin
			plane_dir <= pd_mem[rd.plane_addr];
			plane_off <= po_mem[rd.plane_addr];
		end
	end

endmodule

@@ design/plc_axis_cell.sv @@
// ---------------------------------------------------------------------------
// plc_axis_cell
// One axis of the running sum: squared difference or product, then add.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plc_axis_cell (
	input  logic                               clk,
	input  logic                               en,
	input  logic                               sq,      // 1: (a-b)^2, 0: a*b
	input  logic signed [plc_pkg::COORD_W-1:0] a,
	input  logic signed [plc_pkg::COORD_W-1:0] b,
	input  logic signed [plc_pkg::SUM_W-1:0]   sum_in,
	output logic signed [plc_pkg::SUM_W-1:0]   sum_out
);

	logic signed [plc_pkg::COORD_W:0]   diff;
	logic signed [plc_pkg::COORD_W:0]   m_a;
	logic signed [plc_pkg::COORD_W:0]   m_b;
	logic signed [plc_pkg::PROD_W-1:0]  prod_q;

	assign diff = {a[plc_pkg::COORD_W-1], a} - {b[plc_pkg::COORD_W-1], b};
	assign m_a  = sq ? diff : {a[plc_pkg::COORD_W-1], a};
	assign m_b  = sq ? diff : {b[plc_pkg::COORD_W-1], b};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q  <= plc_pkg::PROD_W'(m_a * m_b);
			sum_out <= sum_in + plc_pkg::SUM_W'(prod_q);
		end
	end

endmodule

@@ design/power_cell_locate_unit.sv @@
// ---------------------------------------------------------------------------
// power_cell_locate_unit
// Point location in a weighted Voronoi diagram over a row of axis cells.
// ---------------------------------------------------------------------------
// Usage: s_axis carries one transaction per item; tuser[1:0] is the mode.
//   Modes 0/1 write a site or boundary plane entry, no result.
//   Modes 2/3 run a query: one pass over plane_count planes, one over
//   site_count sites for the best power value, and in mode 3 a second site
//   pass that lists every site within tolerance of the best.
// Each pass issues one table entry per cycle into three chained axis cells
// (x, y, z), each a multiply stage then an add stage; the running sum moves
// one cell per cycle. A list-mode output stall holds both.
// A query holds the unit busy; s_axis_tready is high only between queries.
// m_axis holds one registered result; a stalled receiver freezes the site
// pipeline when a list match finds the output slot still full.
// cfg writes (index 0 site_count, 1 plane_count) are always ready.
// Reset clears the counts, the sequencer and the output register; the
// tables hold garbage until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "power_cell_locate_unit_defines.svh"

module power_cell_locate_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [1:0]   s_axis_tuser,   // mode
	input  logic [111:0] s_axis_tdata,   // slot, coord_x, coord_y, coord_z, scalar_value, site_tag, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [0:0]   m_axis_tuser,   // found
	output logic [63:0]  m_axis_tdata,   // site_ident, entry_slot, power_value
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [6:0]   cfg_data
);

	localparam int CW = plc_pkg::COORD_W;
	localparam int SW = plc_pkg::SUM_W;

	typedef enum logic [2:0] {IDLE, PLANES, SITES, LIST, FINISH} state_t;

	// input unpack
	logic [1:0]                    in_mode;
	logic [plc_pkg::SLOT_W-1:0]    in_slot;
	logic signed [CW-1:0]          in_x, in_y, in_z;
	logic signed [plc_pkg::SCALAR_W-1:0] in_scalar;
	logic [plc_pkg::TAG_W-1:0]     in_tag;

	assign in_mode   = s_axis_tuser;
	assign in_slot   = s_axis_tdata[5:0];
	assign in_x      = s_axis_tdata[21:6];
	assign in_y      = s_axis_tdata[37:22];
	assign in_z      = s_axis_tdata[53:38];
	assign in_scalar = s_axis_tdata[94:54];
	assign in_tag    = s_axis_tdata[110:95];

	// config
	logic [6:0] site_count_q;
	logic [4:0] plane_count_q;
	logic [plc_pkg::CNT_W-1:0] ns, np;

	localparam logic [1:0] CFG_SITE_COUNT_IDX  = plc_pkg::CFG_SITE_COUNT;
	localparam logic [1:0] CFG_PLANE_COUNT_IDX = plc_pkg::CFG_PLANE_COUNT;

	assign cfg_ready = 1'b1;
	assign ns = (site_count_q > 7'(plc_pkg::MAX_SITES)) ? plc_pkg::CNT_W'(plc_pkg::MAX_SITES)
		: plc_pkg::CNT_W'(site_count_q);
	assign np = (plane_count_q > 5'(plc_pkg::MAX_PLANES)) ? plc_pkg::CNT_W'(plc_pkg::MAX_PLANES)
		: plc_pkg::CNT_W'(plane_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q  <= '0;
			plane_count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SITE_COUNT_IDX:  site_count_q  <= cfg_data;
				CFG_PLANE_COUNT_IDX: plane_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t state_q;
	logic [plc_pkg::CNT_W-1:0] idx_q, ns_q, np_q, limit;
	logic signed [CW-1:0] qx_q, qy_q, qz_q;
	logic signed [plc_pkg::SCALAR_W-1:0] tol_q;
	logic list_q, outside_q;
	logic signed [SW-1:0] best_q;
	logic [plc_pkg::SITE_AW-1:0] best_slot_q;
	logic [plc_pkg::TAG_W-1:0] best_tag_q;
	logic pend_valid_q;
	logic [plc_pkg::SITE_AW-1:0] pend_slot_q;
	logic [plc_pkg::TAG_W-1:0] pend_tag_q;
	logic signed [SW-1:0] pend_pow_q;

	// output register
	logic out_valid_q, out_found_q, out_last_q;
	logic [plc_pkg::TAG_W-1:0] out_tag_q;
	logic [plc_pkg::SLOT_W-1:0] out_slot_q;
	logic [plc_pkg::POWER_W-1:0] out_pow_q;

	// pipeline bookkeeping (s1..s5)
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic [plc_pkg::SITE_AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [plc_pkg::TAG_W-1:0] tag_s2, tag_s3, tag_s4, tag_s5;

	logic s_acc, issuing, issue, en, pipe_empty, pass_done, slot_free;
	logic need_emit, match, in_pass, load_out;
	logic signed [SW-1:0] pow_s5, rel;

	assign s_axis_tready = (state_q == IDLE);
	assign s_acc     = s_axis_tvalid && s_axis_tready;
	assign in_pass   = (state_q == PLANES) || (state_q == SITES) || (state_q == LIST);
	assign limit     = (state_q == PLANES) ? np_q : ns_q;
	assign issuing   = in_pass && (idx_q < limit);
	assign pipe_empty = !(v1_s1 || v2_s2 || v3_s3 || v4_s4 || v5_s5);
	assign pass_done = in_pass && !issuing && pipe_empty;
	assign slot_free = !out_valid_q || m_axis_tready;
	assign rel       = pow_s5 - best_q;
	assign match     = (rel <= SW'(tol_q));
	assign need_emit = (state_q == LIST) && v5_s5 && match && pend_valid_q;
	assign en        = !(need_emit && !slot_free);
	assign issue     = issuing && en;
	// output register reloads this cycle
	assign load_out  = (need_emit && en) || ((state_q == FINISH) && slot_free);

	// tables
	plc_pkg::tbl_wr_t tbl_wr;
	plc_pkg::tbl_rd_t tbl_rd;
	logic signed [CW-1:0] t_sx, t_sy, t_sz;
	logic signed [plc_pkg::SCALAR_W-1:0] t_sw, t_poff;
	logic [plc_pkg::TAG_W-1:0] t_tag;
	logic [3*CW-1:0] t_pdir;

	always_comb begin
		tbl_wr.site_we  = s_acc && (in_mode == plc_pkg::MODE_WR_SITE);
		tbl_wr.plane_we = s_acc && (in_mode == plc_pkg::MODE_WR_PLANE);
		tbl_wr.slot     = in_slot;
		tbl_wr.x        = in_x;
		tbl_wr.y        = in_y;
		tbl_wr.z        = in_z;
		tbl_wr.scalar   = in_scalar;
		tbl_wr.tag      = in_tag;
		tbl_rd.rd_en      = issue;
		tbl_rd.site_addr  = idx_q[plc_pkg::SITE_AW-1:0];
		tbl_rd.plane_addr = idx_q[plc_pkg::PLANE_AW-1:0];
	end

	plc_tables u_tables (
		.clk       (clk),
		.wr        (tbl_wr),
		.rd        (tbl_rd),
		.site_x    (t_sx),
		.site_y    (t_sy),
		.site_z    (t_sz),
		.site_w    (t_sw),
		.site_tag  (t_tag),
		.plane_dir (t_pdir),
		.plane_off (t_poff)
	);

	// s1 operand select: planes use dot product, sites squared distance
	logic is_plane, sq;
	logic signed [CW-1:0] bx_s1, by_s1, bz_s1, by_s2, bz_s2, bz_s3;
	logic signed [plc_pkg::SCALAR_W-1:0] sc_s1;
	logic signed [SW-1:0] neg_s2, sum_x, sum_y;

	assign is_plane = (state_q == PLANES);
	assign sq       = !is_plane;
	assign bx_s1 = is_plane ? t_pdir[CW-1:0]      : t_sx;
	assign by_s1 = is_plane ? t_pdir[2*CW-1:CW]   : t_sy;
	assign bz_s1 = is_plane ? t_pdir[3*CW-1:2*CW] : t_sz;
	assign sc_s1 = is_plane ? t_poff : t_sw;

	// skew the y and z operands so each cell meets the running sum; delay the negated scalar, tags and indices alongside
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= -SW'(sc_s1);
			by_s2  <= by_s1;
			bz_s2  <= bz_s1;
			bz_s3  <= bz_s2;
			tag_s2 <= t_tag;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			idx_s4 <= idx_s3;
			idx_s5 <= idx_s4;
		end
		if (issue) begin
			idx_s1 <= idx_q[plc_pkg::SITE_AW-1:0];
		end
	end

	plc_axis_cell u_cell_x (.clk(clk), .en(en), .sq(sq), .a(qx_q), .b(bx_s1),
		.sum_in(neg_s2), .sum_out(sum_x));
	plc_axis_cell u_cell_y (.clk(clk), .en(en), .sq(sq), .a(qy_q), .b(by_s2),
		.sum_in(sum_x), .sum_out(sum_y));
	plc_axis_cell u_cell_z (.clk(clk), .en(en), .sq(sq), .a(qz_q), .b(bz_s3),
		.sum_in(sum_y), .sum_out(pow_s5));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else if (en) begin
			v1_s1 <= issue;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
		end
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			idx_q        <= '0;
			ns_q         <= '0;
			np_q         <= '0;
			list_q       <= 1'b0;
			outside_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			case (state_q)
				IDLE: begin
					if (s_acc && (in_mode == plc_pkg::MODE_LOCATE
							|| in_mode == plc_pkg::MODE_LIST)) begin
						qx_q         <= in_x;
						qy_q         <= in_y;
						qz_q         <= in_z;
						tol_q        <= in_scalar;
						list_q       <= (in_mode == plc_pkg::MODE_LIST);
						ns_q         <= ns;
						np_q         <= np;
						idx_q        <= '0;
						outside_q    <= 1'b0;
						pend_valid_q <= 1'b0;
						if (np != '0) begin
							state_q <= PLANES;
						end else if (ns != '0) begin
							state_q <= SITES;
						end else begin
							state_q <= FINISH;
						end
					end
				end
				PLANES: begin
					if (v5_s5 && (pow_s5 > 0)) begin
						outside_q <= 1'b1;
					end
					if (pass_done) begin
						idx_q <= '0;
						state_q <= (outside_q || ns_q == '0) ? FINISH : SITES;
					end
				end
				SITES: begin
					if (v5_s5 && (idx_s5 == '0 || pow_s5 < best_q)) begin
						best_q      <= pow_s5;
						best_slot_q <= idx_s5;
						best_tag_q  <= tag_s5;
					end
					if (pass_done) begin
						idx_q <= '0;
						if (list_q) begin
							state_q <= LIST;
						end else begin
							pend_valid_q <= 1'b1;
							pend_pow_q   <= best_q;
							pend_slot_q  <= best_slot_q;
							pend_tag_q   <= best_tag_q;
							state_q      <= FINISH;
						end
					end
				end
				LIST: begin
					if (v5_s5 && match && en) begin
						if (pend_valid_q) begin
							out_valid_q <= 1'b1;
							out_found_q <= 1'b1;
							out_last_q  <= 1'b0;
							out_tag_q   <= pend_tag_q;
							out_slot_q  <= plc_pkg::SLOT_W'(pend_slot_q);
							out_pow_q   <= pend_pow_q[plc_pkg::POWER_W-1:0];
						end
						pend_valid_q <= 1'b1;
						pend_pow_q   <= pow_s5;
						pend_slot_q  <= idx_s5;
						pend_tag_q   <= tag_s5;
					end
					if (pass_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= pend_valid_q;
						out_last_q  <= 1'b1;
						out_tag_q   <= pend_valid_q ? pend_tag_q : '0;
						out_slot_q  <= pend_valid_q ? plc_pkg::SLOT_W'(pend_slot_q) : '0;
						out_pow_q   <= pend_valid_q ? pend_pow_q[plc_pkg::POWER_W-1:0] : '0;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {out_pow_q, out_slot_q, out_tag_q};

	// checks
	`PLC_ASSERT_NOW(a_idle_pipe_empty, clk, arst_n, s_axis_tready,
		!(v1_s1 || v2_s2 || v3_s3 || v4_s4 || v5_s5))
	`PLC_ASSERT_NOW(a_stall_only_in_list, clk, arst_n, !en, state_q == LIST)
	`PLC_ASSERT_NEXT(a_finish_emits_last, clk, arst_n,
		state_q == FINISH && slot_free, out_valid_q && out_last_q)

endmodule
